/* rtl/all_pairs_hop_distance_assert.svh */
// Assertion macros used by the checker of this block.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef ALL_PAIRS_HOP_DISTANCE_ASSERT_SVH
`define ALL_PAIRS_HOP_DISTANCE_ASSERT_SVH

// Same-cycle implication.
`define APHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APHD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aphd_pkg.sv */
`timescale 1ns / 1ps
package aphd_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int COUNT_W   = $clog2(MAX_NODES + 1);
  localparam int DIST_W    = 7;
  localparam int WEIGHT_W  = 17;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_EDGE    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE2,
    ST_CLEAR,
    ST_LOAD,
    ST_COL,
    ST_ROW
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LOAD,
    RD_COL,
    RD_ROW,
    RD_QUERY
  } rd_kind_t;

  // Chain control: shift moves every cell one place toward the head,
  // load selects fresh memory data into the tail instead of the head.
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  // 5^-(d-1) in UQ1.16, rounded to nearest.
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [DIST_W-1:0] d);
    logic [WEIGHT_W-1:0] w;
    case (d)
      7'd0, 7'd1: w = 17'd65536;
      7'd2:       w = 17'd13107;
      7'd3:       w = 17'd2621;
      7'd4:       w = 17'd524;
      7'd5:       w = 17'd105;
      7'd6:       w = 17'd21;
      7'd7:       w = 17'd4;
      7'd8:       w = 17'd1;
      default:    w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/aphd_mem.sv */
`timescale 1ns / 1ps
module aphd_mem
  import aphd_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DIST_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DIST_W-1:0] rdata
);

  logic [DIST_W-1:0] mem [DEPTH];
  logic [DIST_W-1:0] rdata_r;

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/aphd_cell.sv */
`timescale 1ns / 1ps
module aphd_cell
  import aphd_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [DIST_W-1:0] din,
  output logic [DIST_W-1:0] dout
);

  logic [DIST_W-1:0] val_r;
  logic [DIST_W-1:0] val_nxt;

  // Take the neighbor's entry on a shift, else hold
  always_comb begin
    val_nxt = shift ? din : val_r;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign dout = val_r;

endmodule

/* rtl/aphd_chain.sv */
`timescale 1ns / 1ps
module aphd_chain
  import aphd_pkg::*;
(
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [DIST_W-1:0] load_data,
  output logic [DIST_W-1:0] head
);

  logic [DIST_W-1:0] q [MAX_NODES];
  logic [DIST_W-1:0] tail_in;

  // Feed the tail from memory while loading, else recirculate the head
  assign tail_in = ctl.load ? load_data : q[0];

  for (genvar c = 0; c < MAX_NODES; c++) begin : g_cell
    logic [DIST_W-1:0] din;
    if (c == MAX_NODES - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_mid
      assign din = q[c+1];
    end
    aphd_cell u_cell (
      .clk  (clk),
      .shift(ctl.shift),
      .din  (din),
      .dout (q[c])
    );
  end

  assign head = q[0];

endmodule

/* rtl/all_pairs_hop_distance.sv */
`timescale 1ns / 1ps
// All-pairs hop distances of an undirected unweighted graph held in a
// 64 x 64 matrix of 7-bit entries. An edge takes one write per direction
// on the single write port; a query's word is read through the registered
// read port and then registered as the result. In a compute, for each
// pivot k, row k is read into a chain
// of 64 cells, then each row i streams past the rotating chain at one
// relaxation per cycle, paced by the one read port of the matrix memory.
// The matrix is undefined until a clear; node_count is to be written only
// while the block is idle. The block itself does not enforce this.
module all_pairs_hop_distance
  import aphd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,     // node_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // first_node[5:0], second_node[11:6], zero pad
  input  logic [1:0]  in_tuser,      // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // hop_distance[6:0], attraction_weight[23:7]
);

  localparam logic [NODE_W-1:0] J_LAST = NODE_W'(MAX_NODES - 1);

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [NODE_W-1:0] eb_r, eb_nxt, ea_r, ea_nxt;
  logic [COUNT_W-1:0] nc_r;
  logic [COUNT_W-1:0] n_eff, n_m1;

  rd_kind_t          rd_kind_r, rd_kind_nxt;
  logic [NODE_W-1:0] rd_i_r, rd_i_nxt, rd_j_r, rd_j_nxt;
  logic              q_oor_r, q_oor_nxt, q_diag_r, q_diag_nxt;
  logic [DIST_W-1:0] dik_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_hop_r;
  logic [WEIGHT_W-1:0] out_w_r;

  logic [ADDR_W-1:0] raddr, seq_waddr, proc_waddr, waddr;
  logic [DIST_W-1:0] seq_wdata, wdata, rdata, head;
  logic              seq_we, proc_we, accept;
  logic [DIST_W:0]   via;
  chain_ctl_t        ctl;

  logic [NODE_W-1:0] in_a, in_b;
  op_t               in_op;
  logic              a_ok, b_ok, last_i, last_k;

  assign in_a  = in_tdata[NODE_W-1:0];
  assign in_b  = in_tdata[2*NODE_W-1:NODE_W];
  assign in_op = op_t'(in_tuser);

  assign n_eff  = (nc_r > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : nc_r;
  assign n_m1   = n_eff - COUNT_W'(1);
  assign a_ok   = {1'b0, in_a} < n_eff;
  assign b_ok   = {1'b0, in_b} < n_eff;
  assign last_i = {1'b0, i_r} == n_m1;
  assign last_k = {1'b0, k_r} == n_m1;

  // Take a word only when idle, no query read is in flight and the result slot can be freed
  assign in_tready = (state_r == ST_IDLE) && (rd_kind_r != RD_QUERY) &&
                     (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Sequencer: next state, read issue, edge writes and clear sweep writes
  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    ea_nxt      = ea_r;
    eb_nxt      = eb_r;
    rd_kind_nxt = RD_NONE;
    rd_i_nxt    = i_r;
    rd_j_nxt    = j_r;
    q_oor_nxt   = q_oor_r;
    q_diag_nxt  = q_diag_r;
    raddr       = {i_r, j_r};
    seq_we      = 1'b0;
    seq_waddr   = {i_r, j_r};
    seq_wdata   = nc_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              i_nxt = '0;
              j_nxt = '0;
              if (n_eff != '0) state_nxt = ST_CLEAR;
            end
            OP_EDGE: begin
              ea_nxt = in_a;
              eb_nxt = in_b;
              if (a_ok && b_ok) begin
                seq_we    = 1'b1;
                seq_waddr = {in_a, in_b};
                seq_wdata = DIST_W'(1);
                state_nxt = ST_EDGE2;
              end
            end
            OP_COMPUTE: begin
              k_nxt = '0;
              j_nxt = '0;
              if (n_eff != '0) state_nxt = ST_LOAD;
            end
            OP_QUERY: begin
              raddr       = {in_a, in_b};
              rd_kind_nxt = RD_QUERY;
              q_oor_nxt   = !(a_ok && b_ok);
              q_diag_nxt  = in_a == in_b;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE2: begin
        seq_we    = 1'b1;
        seq_waddr = {eb_r, ea_r};
        seq_wdata = DIST_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        seq_we = {1'b0, j_r} < n_eff;
        j_nxt  = j_r + NODE_W'(1);
        if (j_r == J_LAST) begin
          i_nxt = i_r + NODE_W'(1);
          if (last_i) state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        raddr       = {k_r, j_r};
        rd_kind_nxt = RD_LOAD;
        j_nxt       = j_r + NODE_W'(1);
        if (j_r == J_LAST) begin
          i_nxt     = '0;
          state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        raddr       = {i_r, k_r};
        rd_kind_nxt = RD_COL;
        j_nxt       = '0;
        state_nxt   = ST_ROW;
      end
      ST_ROW: begin
        raddr       = {i_r, j_r};
        rd_kind_nxt = RD_ROW;
        j_nxt       = j_r + NODE_W'(1);
        if (j_r == J_LAST) begin
          if (!last_i) begin
            i_nxt     = i_r + NODE_W'(1);
            state_nxt = ST_COL;
          end else if (!last_k) begin
            k_nxt     = k_r + NODE_W'(1);
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Relax the entry that arrived against the chain head
  assign via        = {1'b0, dik_r} + {1'b0, head};
  assign proc_waddr = {rd_i_r, rd_j_r};
  assign proc_we    = (rd_kind_r == RD_ROW) && ({1'b0, rd_j_r} < n_eff) &&
                      (rd_i_r != rd_j_r) && (via < {1'b0, rdata});
  assign ctl.shift  = (rd_kind_r == RD_LOAD) || (rd_kind_r == RD_ROW);
  assign ctl.load   = rd_kind_r == RD_LOAD;

  assign waddr = proc_we ? proc_waddr : seq_waddr;
  assign wdata = proc_we ? via[DIST_W-1:0] : seq_wdata;

  aphd_mem u_mem (
    .clk  (clk),
    .we   (proc_we || seq_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  aphd_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .load_data(rdata),
    .head     (head)
  );

  // Hold the result until taken
  always_comb begin
    if (rd_kind_r == RD_QUERY) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_kind_r   <= RD_NONE;
      out_valid_r <= 1'b0;
      nc_r        <= COUNT_W'(MAX_NODES);
    end else begin
      state_r     <= state_nxt;
      rd_kind_r   <= rd_kind_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) nc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    rd_i_r   <= rd_i_nxt;
    rd_j_r   <= rd_j_nxt;
    q_oor_r  <= q_oor_nxt;
    q_diag_r <= q_diag_nxt;
    if (rd_kind_r == RD_COL) dik_r <= rdata;
    if (rd_kind_r == RD_QUERY) begin
      out_hop_r <= q_oor_r ? nc_r : rdata;
      out_w_r   <= (q_oor_r || q_diag_r) ? '0 : weight_of(rdata);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w_r, out_hop_r};

endmodule

/* rtl/aphd_checker.sv */
`timescale 1ns / 1ps
`include "all_pairs_hop_distance_assert.svh"
module aphd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Result held while stalled
  `APHD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `APHD_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  // Full result slot blocks new words
  `APHD_ASSERT_IMP(a_no_take, out_tvalid && !out_tready, !in_tready, "took word with slot full")
  // Weight never above one
  `APHD_ASSERT_IMP(a_w_max, out_tvalid, out_tdata[23:7] <= 17'd65536, "weight above one")
  // Nonzero weight only for short distances
  `APHD_ASSERT_IMP(a_w_dist, out_tvalid && (out_tdata[23:7] != 17'd0),
                   out_tdata[6:0] <= 7'd8, "weight for far pair")

endmodule

bind all_pairs_hop_distance aphd_checker u_aphd_checker (.*);

/* dv/all_pairs_hop_distance_test.sv */
`timescale 1ns / 1ps
module all_pairs_hop_distance_test;
  import aphd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // first_node[5:0], second_node[11:6], zero pad
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // hop_distance[6:0], attraction_weight[23:7]

  typedef struct {
    logic [DIST_W-1:0]   hop;
    logic [WEIGHT_W-1:0] weight;
  } hop_answer_t;

  // One directed step: a register write, or a word with an optional fixed answer.
  typedef struct {
    bit                  is_cfg;
    op_t                 op;
    logic [5:0]          a;
    logic [5:0]          b;
    bit                  fixed;
    logic [DIST_W-1:0]   hop;
    logic [WEIGHT_W-1:0] weight;
  } step_row_t;

  logic [DIST_W-1:0] hop_mat [MAX_NODES][MAX_NODES];
  logic [6:0]        model_nodes;
  hop_answer_t       pending_answers[$];
  int                error_count;
  bit                no_gaps;
  int                ready_hold;

  all_pairs_hop_distance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // 5^-(d-1) in UQ1.16, halves round up
  function automatic logic [WEIGHT_W-1:0] attraction(input int unsigned d);
    longint unsigned p;
    p = 1;
    if (d <= 1) return 17'd65536;
    for (int e = 1; e < d; e++) begin
      p = p * 5;
      if (p > 131072) return '0;
    end
    return WEIGHT_W'((131072 + p) / (2 * p));
  endfunction

  // Apply one accepted word to the matrix copy; queue the answer of a query.
  task automatic apply_word(input op_t op, input logic [5:0] a, input logic [5:0] b);
    int unsigned n;
    int unsigned via;
    hop_answer_t ans;
    n = (model_nodes < MAX_NODES) ? model_nodes : MAX_NODES;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) hop_mat[i][j] = model_nodes;
      end
      OP_EDGE: begin
        if (a < n && b < n) begin
          hop_mat[a][b] = DIST_W'(1);
          hop_mat[b][a] = DIST_W'(1);
        end
      end
      OP_COMPUTE: begin
        for (int k = 0; k < n; k++)
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
              if (i == j) continue;
              via = hop_mat[i][k] + hop_mat[k][j];
              if (via < hop_mat[i][j]) hop_mat[i][j] = DIST_W'(via);
            end
      end
      default: begin
        if (a >= n || b >= n) begin
          ans.hop = model_nodes;
          ans.weight = '0;
        end else begin
          ans.hop = hop_mat[a][b];
          ans.weight = (a == b) ? 17'd0 : attraction(hop_mat[a][b]);
        end
        pending_answers = {pending_answers, ans};
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold the word until accepted, then feed the predictor.
  task automatic send_word(input op_t op, input logic [5:0] a, input logic [5:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, b, a};
    do @(posedge clk); while (!in_tready);
    apply_word(op, a, b);
  endtask

  // Drain all answers, let the block settle, then write node_count.
  task automatic write_nodes(input logic [6:0] value);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_nodes = value;
  endtask

  // Receiver: random stalls in stretches, and the result check.
  always @(posedge clk) begin
    hop_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[6:0] !== want.hop)
          report_mismatch($sformatf("hop_distance %0d, want %0d",
                                    out_tdata[6:0], want.hop));
        if (out_tdata[23:7] !== want.weight)
          report_mismatch($sformatf("attraction_weight %0d, want %0d",
                                    out_tdata[23:7], want.weight));
      end
    end
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_gaps || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end
  end

  function automatic logic [5:0] pick_node(input int unsigned n);
    if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, (n < 63) ? n : 63));
    return 6'($urandom_range(0, 63));
  endfunction

  step_row_t steps[$];

  function automatic step_row_t row(input op_t op, input int a, input int b,
                                    input bit fixed = 0, input int d = 0,
                                    input int w = 0);
    step_row_t s;
    s.is_cfg = 0; s.op = op; s.a = 6'(a); s.b = 6'(b);
    s.fixed = fixed; s.hop = DIST_W'(d); s.weight = WEIGHT_W'(w);
    return s;
  endfunction

  task automatic add_step(input step_row_t s);
    steps = {steps, s};
  endtask

  initial begin
    int settings[10] = '{1, 2, 4, 7, 10, 12, 64, 3, 9, 6};
    step_row_t s;
    int unsigned n;
    int r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 7'd0;
    in_tvalid = 1'b0;
    in_tdata = 16'd0;
    in_tuser = OP_CLEAR;
    out_tready = 1'b0;
    ready_hold = 0;
    error_count = 0;
    no_gaps = 0;
    model_nodes = 7'd64;
    for (int i = 0; i < MAX_NODES; i++)
      for (int j = 0; j < MAX_NODES; j++) hop_mat[i][j] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset count, extreme nodes, self loop, a path, out of range.
    add_step(row(OP_CLEAR, 0, 0));
    add_step(row(OP_QUERY, 0, 0, 1, 64, 0));
    add_step(row(OP_QUERY, 0, 63, 1, 64, 0));
    add_step(row(OP_EDGE, 0, 63));
    add_step(row(OP_QUERY, 0, 63, 1, 1, 65536));
    add_step(row(OP_QUERY, 63, 0, 1, 1, 65536));
    add_step(row(OP_EDGE, 5, 5));
    add_step(row(OP_QUERY, 5, 5, 1, 1, 0));
    add_step(row(OP_EDGE, 1, 2));
    add_step(row(OP_EDGE, 3, 2));
    add_step(row(OP_EDGE, 3, 4));
    add_step(row(OP_EDGE, 4, 5));
    add_step(row(OP_COMPUTE, 0, 0));
    add_step(row(OP_QUERY, 1, 5));
    add_step(row(OP_QUERY, 1, 3));
    add_step(row(OP_QUERY, 0, 1, 1, 64, 0));
    add_step(row(OP_QUERY, 63, 63, 1, 64, 0));
    s = row(OP_CLEAR, 0, 0); s.is_cfg = 1; s.a = 6'd3;
    add_step(s);
    add_step(row(OP_CLEAR, 0, 0));
    add_step(row(OP_EDGE, 0, 5));
    add_step(row(OP_QUERY, 0, 5, 1, 3, 0));
    add_step(row(OP_QUERY, 2, 2, 1, 3, 0));
    add_step(row(OP_EDGE, 0, 1));
    add_step(row(OP_EDGE, 1, 2));
    add_step(row(OP_COMPUTE, 0, 0));
    add_step(row(OP_QUERY, 0, 2));

    foreach (steps[i]) begin
      s = steps[i];
      if (s.is_cfg) begin
        write_nodes({1'b0, s.a});
      end else begin
        send_word(s.op, s.a, s.b);
        // Override the predicted answer with the one typed into the table.
        if (s.fixed) begin
          pending_answers[pending_answers.size() - 1].hop = s.hop;
          pending_answers[pending_answers.size() - 1].weight = s.weight;
        end
      end
    end

    // Random phases: clear, then edges and queries with an occasional clear and, for small counts, compute.
    foreach (settings[p]) begin
      write_nodes(7'(settings[p]));
      n = settings[p];
      no_gaps = ($urandom_range(0, 2) == 0);
      send_word(OP_CLEAR, 0, 0);
      for (int t = 0; t < 165; t++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_word(OP_CLEAR, pick_node(n), pick_node(n));
        else if (r < 45) send_word(OP_EDGE, pick_node(n), pick_node(n));
        else if (r < 48 && n <= 12) send_word(OP_COMPUTE, pick_node(n), pick_node(n));
        else send_word(OP_QUERY, pick_node(n), pick_node(n));
      end
      send_word(OP_QUERY, 0, 0);
    end
    no_gaps = 0;

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
